>>> rtl/core/hsv2rgb_pkg.sv
// hsv2rgb_pkg: fixed-point formats, hue constants and channel helpers
// for the hsv to rgb converter pipeline
// no dependencies
package hsv2rgb_pkg;

  // fractional bits of saturation, value and the rgb channels
  localparam int unsigned FracBits = 12;
  localparam int unsigned ChanW    = FracBits + 1;
  localparam int unsigned HueW     = 16;

  // hue is in 1/128 degree: a full turn and one 60 degree sector
  localparam logic [HueW-1:0] HueFull   = HueW'(46080);
  localparam logic [HueW-1:0] HueSector = HueW'(7680);
  localparam int unsigned     RemW      = 13;
  localparam int unsigned     SectW     = 3;

  // fraction within a sector: f = (rem << FracBits) / HueSector,
  // done as a multiply by a rounded-up reciprocal and a right shift
  localparam int unsigned RecipShift = 29;
  localparam int unsigned RecipW     = FracBits + 17;
  localparam longint unsigned RecipVal =
      ((64'd1 << (FracBits + RecipShift)) + 64'd7679) / 64'd7680;
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipVal);

  localparam logic [ChanW-1:0] OneQ = ChanW'(1) << FracBits;

  // signed 1 - x and the signed product v * (1 - x)
  localparam int unsigned OmW   = FracBits + 2;
  localparam int unsigned ProdW = 2 * OmW;

  // 60 degree sectors, named by the hues that bound them
  localparam logic [SectW-1:0] SectRedYel = 3'd0;
  localparam logic [SectW-1:0] SectYelGrn = 3'd1;
  localparam logic [SectW-1:0] SectGrnCyn = 3'd2;
  localparam logic [SectW-1:0] SectCynBlu = 3'd3;
  localparam logic [SectW-1:0] SectBluMag = 3'd4;
  localparam logic [SectW-1:0] SectMagRed = 3'd5;

  // limit a channel to 1.0
  function automatic logic [ChanW-1:0] clamp_one(input logic [ChanW-1:0] x);
    return (x > OneQ) ? OneQ : x;
  endfunction

  // v * (1 - x) product back to a channel: zero or less is black, then clamp
  function automatic logic [ChanW-1:0] scale_clamp(input logic signed [ProdW-1:0] p);
    logic [ProdW-FracBits-1:0] sh;
    sh = p[ProdW-1:FracBits];
    if (p <= 0) begin
      return '0;
    end else if (sh > (ProdW-FracBits)'(OneQ)) begin
      return OneQ;
    end else begin
      return sh[ChanW-1:0];
    end
  endfunction

endpackage

>>> rtl/core/hsv_to_rgb_converter_unit.sv
// hsv_to_rgb_converter_unit: six-stage pipelined hsv to rgb pixel converter
// depends on hsv2rgb_pkg for formats, hue constants and channel helpers
//
// usage: one pixel item enters on any cycle with start_i high; busy_o stays
// low, so an item is taken every clock. each result appears on red_o,
// green_o and blue_o for exactly one cycle with done_o high, in the order
// the items came in. the receiver cannot stall the pipeline, so it must
// take every result in the cycle it is shown. hue is in 1/128 degree units
// and wraps at 360 degrees; saturation and value are unsigned q1.12 (4096
// is 1.0); channels are q1.12 clamped to 0..4096. zero value gives black,
// zero saturation gives grey at value. throughput is one item per clock;
// the stage chain is hue wrap, sector split, fraction multiply, saturation
// products, value products, clamp and channel select.
module hsv_to_rgb_converter_unit
  import hsv2rgb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [HueW-1:0]  hue_i,
  input  logic [ChanW-1:0] saturation_i,
  input  logic [ChanW-1:0] value_i,
  output logic             done_o,
  output logic [ChanW-1:0] red_o,
  output logic [ChanW-1:0] green_o,
  output logic [ChanW-1:0] blue_o
);

  localparam int unsigned NumStages = 6;

  // valid bits travel with the data, one per stage
  logic [NumStages-1:0] vld_d, vld_q;

  // stage 1: hue wrapped into one turn
  logic [HueW-1:0]  h1_d, h1_q;
  logic [ChanW-1:0] s1_q, v1_q;

  // stage 2: sector index and remainder within the sector
  logic [SectW-1:0] sect2_d, sect2_q;
  logic [HueW-1:0]  base2;
  logic [HueW-1:0]  rem2_full;
  logic [RemW-1:0]  rem2_q;
  logic [ChanW-1:0] s2_q, v2_q;

  // stage 3: fraction within the sector, q0.12
  logic [RemW+RecipW-1:0] fprod3;
  logic [FracBits-1:0]    f3_d, f3_q;
  logic [SectW-1:0]       sect3_q;
  logic [ChanW-1:0]       s3_q, v3_q;

  // stage 4: s*f and s*(1-f)
  logic [2*ChanW-1:0] sfprod4, sf1prod4;
  logic [ChanW-1:0]   f1m4;
  logic [ChanW-1:0]   sf4_d, sf4_q, sf14_d, sf14_q;
  logic [SectW-1:0]   sect4_q;
  logic [ChanW-1:0]   s4_q, v4_q;

  // stage 5: signed products v*(1-s), v*(1-sf), v*(1-s(1-f))
  logic signed [OmW-1:0]   om_p5, om_q5, om_t5, v_s5;
  logic signed [ProdW-1:0] pp5_d, pp5_q, qp5_d, qp5_q, tp5_d, tp5_q;
  logic [SectW-1:0]        sect5_q;
  logic [ChanW-1:0]        s5_q, v5_q;

  // stage 6: clamp, special cases and channel ordering
  logic [ChanW-1:0] vc6, pv6, qv6, tv6;
  logic [ChanW-1:0] red_d, red_q, green_d, green_q, blue_d, blue_q;

  // nothing ever holds the input off
  assign busy_o = 1'b0;
  assign vld_d  = {vld_q[NumStages-2:0], start_i & ~busy_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // hue wrap: input stays below two turns, so one subtract does it
  assign h1_d = (hue_i >= HueFull) ? (hue_i - HueFull) : hue_i;

  // sector split by compares against sector boundaries
  always_comb begin
    if (h1_q >= HueW'(5 * 7680)) begin
      sect2_d = SectMagRed;
    end else if (h1_q >= HueW'(4 * 7680)) begin
      sect2_d = SectBluMag;
    end else if (h1_q >= HueW'(3 * 7680)) begin
      sect2_d = SectCynBlu;
    end else if (h1_q >= HueW'(2 * 7680)) begin
      sect2_d = SectGrnCyn;
    end else if (h1_q >= HueW'(7680)) begin
      sect2_d = SectYelGrn;
    end else begin
      sect2_d = SectRedYel;
    end
  end

  assign base2     = HueW'(HueSector * HueW'(sect2_d));
  assign rem2_full = h1_q - base2;

  // fraction by reciprocal multiply, truncated
  assign fprod3 = (RemW+RecipW)'(rem2_q) * (RemW+RecipW)'(Recip);
  assign f3_d   = fprod3[RecipShift +: FracBits];

  // saturation products, truncated back to q1.12
  assign f1m4     = OneQ - ChanW'(f3_q);
  assign sfprod4  = (2*ChanW)'(s3_q) * (2*ChanW)'(f3_q);
  assign sf1prod4 = (2*ChanW)'(s3_q) * (2*ChanW)'(f1m4);
  assign sf4_d    = sfprod4[FracBits +: ChanW];
  assign sf14_d   = sf1prod4[FracBits +: ChanW];

  // one minus each term goes negative when saturation is above 1.0
  assign om_p5 = $signed(OmW'(OneQ)) - $signed(OmW'(s4_q));
  assign om_q5 = $signed(OmW'(OneQ)) - $signed(OmW'(sf4_q));
  assign om_t5 = $signed(OmW'(OneQ)) - $signed(OmW'(sf14_q));
  assign v_s5  = $signed(OmW'(v4_q));
  assign pp5_d = ProdW'(v_s5) * ProdW'(om_p5);
  assign qp5_d = ProdW'(v_s5) * ProdW'(om_q5);
  assign tp5_d = ProdW'(v_s5) * ProdW'(om_t5);

  // channel select
  assign vc6 = clamp_one(v5_q);
  assign pv6 = scale_clamp(pp5_q);
  assign qv6 = scale_clamp(qp5_q);
  assign tv6 = scale_clamp(tp5_q);

  always_comb begin
    red_d   = vc6;
    green_d = pv6;
    blue_d  = qv6;
    if (v5_q == '0) begin
      // black
      red_d   = '0;
      green_d = '0;
      blue_d  = '0;
    end else if (s5_q == '0) begin
      // grey at value
      red_d   = vc6;
      green_d = vc6;
      blue_d  = vc6;
    end else begin
      unique case (sect5_q)
        SectRedYel: begin red_d = vc6; green_d = tv6; blue_d = pv6; end
        SectYelGrn: begin red_d = qv6; green_d = vc6; blue_d = pv6; end
        SectGrnCyn: begin red_d = pv6; green_d = vc6; blue_d = tv6; end
        SectCynBlu: begin red_d = pv6; green_d = qv6; blue_d = vc6; end
        SectBluMag: begin red_d = tv6; green_d = pv6; blue_d = vc6; end
        default:    begin red_d = vc6; green_d = pv6; blue_d = qv6; end
      endcase
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    h1_q    <= h1_d;
    s1_q    <= saturation_i;
    v1_q    <= value_i;

    sect2_q <= sect2_d;
    rem2_q  <= rem2_full[RemW-1:0];
    s2_q    <= s1_q;
    v2_q    <= v1_q;

    f3_q    <= f3_d;
    sect3_q <= sect2_q;
    s3_q    <= s2_q;
    v3_q    <= v2_q;

    sf4_q   <= sf4_d;
    sf14_q  <= sf14_d;
    sect4_q <= sect3_q;
    s4_q    <= s3_q;
    v4_q    <= v3_q;

    pp5_q   <= pp5_d;
    qp5_q   <= qp5_d;
    tp5_q   <= tp5_d;
    sect5_q <= sect4_q;
    s5_q    <= s4_q;
    v5_q    <= v4_q;

    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
  end

  assign done_o  = vld_q[NumStages-1];
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

  // every channel leaves within 0..1.0
  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (red_o <= OneQ) && (green_o <= OneQ) && (blue_o <= OneQ))
    else $error("channel above 1.0");

  // zero value in stage five gives black at the output
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NumStages-2] && (v5_q == '0)) |=>
      done_o && (red_o == '0) && (green_o == '0) && (blue_o == '0))
    else $error("zero value did not give black");

  // zero saturation with nonzero value gives grey
  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NumStages-2] && (s5_q == '0) && (v5_q != '0)) |=>
      done_o && (red_o == green_o) && (green_o == blue_o))
    else $error("zero saturation did not give grey");

  // the fraction stage never sees a remainder outside one sector
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] |-> (RemW'(rem2_q) < RemW'(HueSector)))
    else $error("sector remainder out of range");

endmodule

>>> tb/hsv_to_rgb_converter_unit_tb.sv
// hsv_to_rgb_converter_unit_tb: self-checking bench for the hsv to rgb pixel converter
// depends on hsv2rgb_pkg and hsv_to_rgb_converter_unit; directed corners then random pixels,
// every result compared channel by channel against an in-bench fixed-point model
module hsv_to_rgb_converter_unit_tb;
  import hsv2rgb_pkg::*;

  // cycles without any accepted item or result before the run is abandoned
  localparam int QuietLimit = 2000;
  // pipeline is six deep, leave generous slack after the last result
  localparam int TailCycles = 16;
  localparam int HueFullI   = int'(HueFull);
  localparam int HueSectI   = int'(HueSector);
  localparam int OneI       = int'(OneQ);

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             start_i      = 1'b0;
  logic [HueW-1:0]  hue_i        = '0;
  logic [ChanW-1:0] saturation_i = '0;
  logic [ChanW-1:0] value_i      = '0;
  logic             busy_o;
  logic             done_o;
  logic [ChanW-1:0] red_o;
  logic [ChanW-1:0] green_o;
  logic [ChanW-1:0] blue_o;

  // colors still on their way through the pipeline, oldest first
  rgb_t rgb_pending_q[$];

  int   n_sent    = 0;
  int   n_checked = 0;
  int   n_errors  = 0;
  int   quiet_cnt = 0;
  // when set the sender drops start at random between items
  bit   gaps_on   = 1'b1;

  always #5 clk_i = ~clk_i;

  hsv_to_rgb_converter_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

  // clamp a channel to 1.0
  function automatic int chan_limit(input int x);
    return (x > OneI) ? OneI : x;
  endfunction

  // v * (1 - x): non-positive products are black, else drop the fraction and clamp
  function automatic int value_times(input int v, input int one_minus);
    int prod;
    prod = v * one_minus;
    if (prod <= 0) begin
      return 0;
    end
    return chan_limit(prod >>> FracBits);
  endfunction

  // expected color of one pixel, bit exact with the fixed-point spec
  function automatic rgb_t hsv_to_rgb_predict(input logic [HueW-1:0] hue,
                                              input logic [ChanW-1:0] sat,
                                              input logic [ChanW-1:0] val);
    int   h;
    int   s;
    int   v;
    int   sector;
    int   frac;
    int   s_frac;
    int   s_frac_inv;
    int   vc;
    int   pv;
    int   qv;
    int   tv;
    int   r;
    int   g;
    int   b;
    rgb_t px;
    h = int'(hue);
    s = int'(sat);
    v = int'(val);
    // a 16-bit hue is below two turns, so one subtraction wraps it
    if (h >= HueFullI) begin
      h = h - HueFullI;
    end
    if (v == 0) begin
      // black wins over everything
      r = 0;
      g = 0;
      b = 0;
    end else if (s == 0) begin
      // grey at value, value may exceed 1.0
      r = chan_limit(v);
      g = r;
      b = r;
    end else begin
      sector     = h / HueSectI;
      frac       = ((h % HueSectI) << FracBits) / HueSectI;
      s_frac     = (s * frac) >> FracBits;
      s_frac_inv = (s * (OneI - frac)) >> FracBits;
      vc         = chan_limit(v);
      // saturation above 1.0 can push these below zero, they then read as 0
      pv         = value_times(v, OneI - s);
      qv         = value_times(v, OneI - s_frac);
      tv         = value_times(v, OneI - s_frac_inv);
      case (SectW'(sector))
        SectRedYel: begin r = vc; g = tv; b = pv; end
        SectYelGrn: begin r = qv; g = vc; b = pv; end
        SectGrnCyn: begin r = pv; g = vc; b = tv; end
        SectCynBlu: begin r = pv; g = qv; b = vc; end
        SectBluMag: begin r = tv; g = pv; b = vc; end
        default:    begin r = vc; g = pv; b = qv; end
      endcase
    end
    px.red   = ChanW'(r);
    px.green = ChanW'(g);
    px.blue  = ChanW'(b);
    return px;
  endfunction

  // scoreboard and watchdog: results are compared before this edge's item is
  // queued, all values are the ones that were stable before the edge
  always @(posedge clk_i) begin : result_check
    rgb_t want;
    logic took_item;
    if (rst_ni) begin
      took_item = start_i && !busy_o;
      if (done_o) begin
        if (rgb_pending_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result, expected none, actual r=%0d g=%0d b=%0d",
                   $time, red_o, green_o, blue_o);
        end else begin
          want = rgb_pending_q.pop_front();
          n_checked++;
          if (red_o !== want.red) begin
            n_errors++;
            $display("%0t: red mismatch, expected %0d, actual %0d", $time, want.red, red_o);
          end
          if (green_o !== want.green) begin
            n_errors++;
            $display("%0t: green mismatch, expected %0d, actual %0d",
                     $time, want.green, green_o);
          end
          if (blue_o !== want.blue) begin
            n_errors++;
            $display("%0t: blue mismatch, expected %0d, actual %0d", $time, want.blue, blue_o);
          end
        end
      end
      if (took_item) begin
        rgb_pending_q.push_back(hsv_to_rgb_predict(hue_i, saturation_i, value_i));
      end
      // watchdog: any traffic at all restarts the count
      if (took_item || done_o) begin
        quiet_cnt = 0;
      end else begin
        quiet_cnt++;
      end
      if (quiet_cnt >= QuietLimit) begin
        $display("watchdog: no item or result for %0d cycles", QuietLimit);
        $display("hsv_to_rgb_converter_unit_tb NOT OK");
        $finish;
      end
    end
  end

  // present one pixel and hold it until the block takes it; while idling the
  // fields carry junk so that only start qualifies them
  task automatic send_pixel(input logic [HueW-1:0] h,
                            input logic [ChanW-1:0] s,
                            input logic [ChanW-1:0] v);
    while (gaps_on && ($urandom_range(99) < 32)) begin
      start_i      <= 1'b0;
      hue_i        <= HueW'($urandom);
      saturation_i <= ChanW'($urandom);
      value_i      <= ChanW'($urandom);
      @(posedge clk_i);
    end
    start_i      <= 1'b1;
    hue_i        <= h;
    saturation_i <= s;
    value_i      <= v;
    @(posedge clk_i);
    while (busy_o) begin
      @(posedge clk_i);
    end
    n_sent++;
  endtask

  // drop start and hold off until every queued color has come back;
  // checked on the falling edge so the scoreboard has settled
  task automatic wait_pipeline_empty();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (rgb_pending_q.size() != 0) begin
      @(negedge clk_i);
    end
    @(posedge clk_i);
  endtask

  // biased random pixel: mostly in-range values with sector edges mixed in,
  // some full-width values for the over-range paths and every bit
  task automatic send_random_pixel();
    logic [HueW-1:0]  h;
    logic [ChanW-1:0] s;
    logic [ChanW-1:0] v;
    if ($urandom_range(4) == 0) begin
      // near a sector edge, possibly in the wrapped second turn
      h = HueW'($urandom_range(0, 8) * HueSectI + $urandom_range(0, 2) - 1);
    end else begin
      h = HueW'($urandom_range(0, 65535));
    end
    case ($urandom_range(9))
      0, 1, 2: s = ChanW'($urandom_range(0, 8191));
      3:       s = ($urandom_range(1) == 0) ? '0 : OneQ;
      default: s = ChanW'($urandom_range(0, OneI));
    endcase
    case ($urandom_range(9))
      0, 1, 2: v = ChanW'($urandom_range(0, 8191));
      3:       v = ($urandom_range(1) == 0) ? ChanW'(1) : OneQ;
      4:       v = '0;
      default: v = ChanW'($urandom_range(0, OneI));
    endcase
    send_pixel(h, s, v);
  endtask

  // zero value is black regardless of hue and saturation
  task automatic test_black();
    send_pixel(HueW'(0), OneQ, '0);
    send_pixel(HueW'(30000), ChanW'(8191), '0);
    send_pixel(HueW'(65535), '0, '0);
  endtask

  // zero saturation is grey, value above 1.0 clamps
  task automatic test_grey();
    send_pixel(HueW'(1234), '0, ChanW'(1));
    send_pixel(HueW'(20000), '0, OneQ);
    send_pixel(HueW'(46079), '0, ChanW'(8191));
  endtask

  // hue at zero, sector edges, the 360 degree wrap and the top code
  task automatic test_hue_wrap();
    send_pixel(HueW'(0), OneQ, OneQ);
    send_pixel(HueW'(7679), OneQ, OneQ);
    send_pixel(HueW'(7680), OneQ, OneQ);
    send_pixel(HueW'(46079), OneQ, OneQ);
    send_pixel(HueW'(46080), OneQ, OneQ);
    send_pixel(HueW'(53759), OneQ, OneQ);
    send_pixel(HueW'(65535), OneQ, OneQ);
  endtask

  // middle of each of the six sectors
  task automatic test_sectors();
    for (int k = 0; k < 6; k++) begin
      send_pixel(HueW'(k * HueSectI + HueSectI / 2), ChanW'(3000), ChanW'(3500));
    end
  endtask

  // saturation and value above 1.0, negative p, q and t read as black channels
  task automatic test_over_range();
    send_pixel(HueW'(10000), ChanW'(8191), ChanW'(8191));
    send_pixel(HueW'(40000), ChanW'(6000), ChanW'(5000));
    send_pixel(HueW'(3000), ChanW'(1), ChanW'(8191));
  endtask

  // a long stream with start held high, one item per clock
  task automatic test_back_to_back();
    gaps_on = 1'b0;
    repeat (150) begin
      send_random_pixel();
    end
    gaps_on = 1'b1;
  endtask

  // bursts separated by a full drain of the pipeline
  task automatic test_drain_pause();
    repeat (3) begin
      repeat (20) begin
        send_random_pixel();
      end
      wait_pipeline_empty();
    end
  endtask

  // random pixels with random gaps, drained now and then
  task automatic test_random_gaps();
    for (int i = 0; i < 430; i++) begin
      send_random_pixel();
      if ((i % 100) == 99) begin
        wait_pipeline_empty();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_black();
    test_grey();
    test_hue_wrap();
    test_sectors();
    test_over_range();
    test_back_to_back();
    test_drain_pause();
    test_random_gaps();

    // let the last colors come out, then watch for strays
    wait_pipeline_empty();
    repeat (TailCycles) @(posedge clk_i);

    $display("sent %0d pixels: black, grey, hue wrap, six sectors, over-range inputs,",
             n_sent);
    $display("gapless and gapped streams with drains; %0d colors compared, %0d mismatches",
             n_checked, n_errors);
    if (n_errors == 0 && rgb_pending_q.size() == 0) begin
      $display("hsv_to_rgb_converter_unit_tb OK");
    end else begin
      $display("hsv_to_rgb_converter_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/hsv2rgb_pkg.sv
rtl/core/hsv_to_rgb_converter_unit.sv
tb/hsv_to_rgb_converter_unit_tb.sv
